### sv/acrm_pkg.sv
// ----------------------------------------------------------------------------
// acrm_pkg: shared types and codes for the admission credit reorder mailbox
// Holds opcode, result kind, status and config codes, beat and command structs and FSM state.
// ----------------------------------------------------------------------------
`default_nettype none
package acrm_pkg;

    typedef enum logic [2:0] {
        OP_ADMIT    = 3'd0,
        OP_COMPLETE = 3'd1,
        OP_RELEASE  = 3'd2,
        OP_DRAIN    = 3'd3,
        OP_CLOSE    = 3'd4
    } opcode_t;

    localparam logic [2:0] KIND_ADMIT     = 3'd0;
    localparam logic [2:0] KIND_COMPLETE  = 3'd1;
    localparam logic [2:0] KIND_RELEASE   = 3'd2;
    localparam logic [2:0] KIND_DELIVER   = 3'd3;
    localparam logic [2:0] KIND_DRAIN_END = 3'd4;
    localparam logic [2:0] KIND_CLOSE     = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REFUSED   = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_WINDOW    = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;

    localparam logic [2:0] CFG_MAX_ORD_OPS   = 3'd0;
    localparam logic [2:0] CFG_MAX_ORD_BYTES = 3'd1;
    localparam logic [2:0] CFG_MAX_RES_OPS   = 3'd2;
    localparam logic [2:0] CFG_MAX_RES_BYTES = 3'd3;
    localparam logic [2:0] CFG_DRAIN_BATCH   = 3'd4;
    localparam logic [2:0] CFG_WORKERS       = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        lane;
        logic [31:0] byte_cost;
        logic [15:0] sequence_req;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [15:0] out_sequence;
        logic [31:0] out_payload;
        logic        more_pending;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN_RD,
        S_DRAIN_WB,
        S_DRAIN_END
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;     // latch request
        logic exec;        // run single-step op, emit its reply
        logic drain_rd;    // read head slot
        logic drain_wb;    // deliver head slot, advance
        logic drain_end;   // emit drain end beat
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_drain;
        logic is_valid_op;
        logic head_full;
        logic batch_done;
    } sts_t;

endpackage
`default_nettype wire

### sv/admission_credit_reorder_mailbox.sv
// ----------------------------------------------------------------------------
// admission_credit_reorder_mailbox: credit admission with in-order mailbox
// Grants lane credits, stores tagged results and drains them in sequence.
// ----------------------------------------------------------------------------
//  channel   handshake             beat
//  request   start & !busy         req (req_t)
//  result    result_strobe         result (rsp_t), one cycle, no stall
//  config    cfg_valid & cfg_ready cfg_index, cfg_data
//
// Admit, complete, release and close are a capture, then one read-modify-write
// of counters, slot flags or the close flag. Drain captures, then reads and
// delivers each head slot in turn and ends with a drain end beat: each slot is
// read into a register and delivered in the next cycle, one memory port. Reset
// clears counters and slot flags at once; the slot memory itself holds no
// reset. Results cannot be stalled.
`default_nettype none
module admission_credit_reorder_mailbox
    import acrm_pkg::*;
#(
    parameter int REORDER_SLOTS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  req_t             req,
    output logic             result_strobe,
    output rsp_t             result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Config is taken whenever offered
    assign cfg_ready = 1'b1;

    acrm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    acrm_dp #(.REORDER_SLOTS(REORDER_SLOTS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
`default_nettype wire

### sv/acrm_ctrl.sv
// ----------------------------------------------------------------------------
// acrm_ctrl: sequencing state machine
// Steps each command through execute or the drain walk.
// ----------------------------------------------------------------------------
`default_nettype none
module acrm_ctrl
    import acrm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  sts_t      sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_drain)
                begin
                    if (sts.head_full && !sts.batch_done)
                    begin
                        cmd.drain_rd = 1'b1;
                        state_next   = S_DRAIN_WB;
                    end
                    else
                    begin
                        state_next = S_DRAIN_END;
                    end
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DRAIN_RD:
            begin
                if (sts.head_full && !sts.batch_done)
                begin
                    cmd.drain_rd = 1'b1;
                    state_next   = S_DRAIN_WB;
                end
                else
                begin
                    state_next = S_DRAIN_END;
                end
            end
            S_DRAIN_WB:
            begin
                cmd.drain_wb = 1'b1;
                state_next   = S_DRAIN_RD;
            end
            S_DRAIN_END:
            begin
                cmd.drain_end = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A delivery write-back always follows a head read
    a_wb_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_rd |=> cmd.drain_wb)
        else $error("write-back did not follow head read");

    // Busy is high the cycle after a capture
    a_busy_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> busy)
        else $error("capture did not raise busy");

    // Only one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("several commands at once");

endmodule
`default_nettype wire

### sv/acrm_dp.sv
// ----------------------------------------------------------------------------
// acrm_dp: credit counters, reorder slots and result register
// Executes commands from the controller; one slot access per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module acrm_dp
    import acrm_pkg::*;
#(
    parameter int REORDER_SLOTS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  req_t             req,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output rsp_t             result,
    output logic             result_strobe
);

    localparam int IW = $clog2(REORDER_SLOTS);

    // Configuration
    logic [12:0] max_ord_ops_reg, max_res_ops_reg;
    logic [31:0] max_ord_bytes_reg, max_res_bytes_reg;
    logic [5:0]  drain_batch_reg;
    logic        workers_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ord_ops_reg   <= 13'd32;
            max_ord_bytes_reg <= 32'd65536;
            max_res_ops_reg   <= 13'd8;
            max_res_bytes_reg <= 32'd16384;
            drain_batch_reg   <= 6'd1;
            workers_reg       <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_ORD_OPS:   max_ord_ops_reg   <= cfg_data[12:0];
                CFG_MAX_ORD_BYTES: max_ord_bytes_reg <= cfg_data;
                CFG_MAX_RES_OPS:   max_res_ops_reg   <= cfg_data[12:0];
                CFG_MAX_RES_BYTES: max_res_bytes_reg <= cfg_data;
                CFG_DRAIN_BATCH:   drain_batch_reg   <= cfg_data[5:0];
                CFG_WORKERS:       workers_reg       <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Architectural state
    logic [12:0] ops_reg   [2];
    logic [31:0] bytes_reg [2];
    logic [15:0] issue_seq_reg, deliver_seq_reg;
    logic [IW-1:0] head_reg;
    logic [IW:0]   stored_reg;
    logic        closed_reg;
    logic [REORDER_SLOTS-1:0] full_reg;
    logic [5:0]  done_reg;
    req_t        req_reg;

    // Slot memory: payload, lane, bytes
    logic [64:0] slot_mem [REORDER_SLOTS];
    logic [64:0] rd_data_reg;

    // Request decode
    logic        ln;
    logic [12:0] cur_ops, max_ops;
    logic [31:0] cur_bytes, max_bytes;
    logic [32:0] sum_bytes;
    logic        grant, rel_under;
    logic [15:0] off, issued;
    logic        in_window;
    logic [IW:0]   wsum;
    logic [IW-1:0] widx;
    logic        dup;
    logic [5:0]  limit;

    // Next result beat
    rsp_t        result_next;
    logic        strobe_next;

    assign ln        = req_reg.lane;
    assign cur_ops   = ops_reg[ln];
    assign cur_bytes = bytes_reg[ln];
    assign max_ops   = ln ? max_res_ops_reg : max_ord_ops_reg;
    assign max_bytes = ln ? max_res_bytes_reg : max_ord_bytes_reg;
    assign sum_bytes = {1'b0, cur_bytes} + {1'b0, req_reg.byte_cost};
    assign grant     = !closed_reg && workers_reg && (cur_ops < max_ops)
                       && (sum_bytes <= {1'b0, max_bytes});
    assign rel_under = (cur_ops == 13'd0) || (cur_bytes < req_reg.byte_cost);
    assign off       = req_reg.sequence_req - deliver_seq_reg;
    assign issued    = issue_seq_reg - deliver_seq_reg;
    assign in_window = ({16'd0, off} < 32'(REORDER_SLOTS)) && (off < issued);
    // Wrap head plus offset around the slot count
    assign wsum      = {1'b0, head_reg} + {1'b0, off[IW-1:0]};
    assign widx      = (wsum >= (IW+1)'(REORDER_SLOTS))
                       ? IW'(wsum - (IW+1)'(REORDER_SLOTS)) : wsum[IW-1:0];
    assign dup       = full_reg[widx];
    assign limit     = (drain_batch_reg == 6'd0) ? 6'd1 : drain_batch_reg;

    assign sts.is_drain    = (req_reg.opcode == OP_DRAIN);
    assign sts.is_valid_op = (req_reg.opcode <= OP_CLOSE);
    assign sts.head_full   = full_reg[head_reg];
    assign sts.batch_done  = (done_reg == limit);

    // Delivery underflow from registered slot data
    logic        d_lane;
    logic [31:0] d_bytes;
    logic        d_under;
    assign d_lane  = rd_data_reg[64];
    assign d_bytes = rd_data_reg[31:0];
    assign d_under = (ops_reg[d_lane] == 13'd0) || (bytes_reg[d_lane] < d_bytes);

    always_comb
    begin
        result_next = '0;
        strobe_next = 1'b0;
        if (cmd.exec && sts.is_valid_op)
        begin
            strobe_next      = 1'b1;
            result_next.last = 1'b1;
            case (req_reg.opcode)
                OP_ADMIT:
                begin
                    result_next.kind = KIND_ADMIT;
                    if (grant)
                        result_next.out_sequence = issue_seq_reg;
                    else
                        result_next.status = ST_REFUSED;
                end
                OP_COMPLETE:
                begin
                    result_next.kind = KIND_COMPLETE;
                    if (!in_window)
                        result_next.status = ST_WINDOW;
                    else if (dup)
                        result_next.status = ST_DUPLICATE;
                end
                OP_RELEASE:
                begin
                    result_next.kind = KIND_RELEASE;
                    if (rel_under)
                        result_next.status = ST_UNDERFLOW;
                end
                OP_CLOSE:
                begin
                    result_next.kind = KIND_CLOSE;
                end
                default: ;
            endcase
        end
        else if (cmd.drain_wb)
        begin
            strobe_next              = 1'b1;
            result_next.kind         = KIND_DELIVER;
            result_next.status       = d_under ? ST_UNDERFLOW : ST_OK;
            result_next.out_sequence = deliver_seq_reg;
            result_next.out_payload  = rd_data_reg[63:32];
        end
        else if (cmd.drain_end)
        begin
            strobe_next              = 1'b1;
            result_next.kind         = KIND_DRAIN_END;
            result_next.more_pending = sts.batch_done && (stored_reg != '0);
            result_next.last         = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
        if (cmd.exec && req_reg.opcode == OP_COMPLETE && in_window && !dup)
            slot_mem[widx] <= {req_reg.lane, req_reg.payload, req_reg.byte_cost};
        if (cmd.drain_rd)
            rd_data_reg <= slot_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ops_reg[0]      <= '0;
            ops_reg[1]      <= '0;
            bytes_reg[0]    <= '0;
            bytes_reg[1]    <= '0;
            issue_seq_reg   <= '0;
            deliver_seq_reg <= '0;
            head_reg        <= '0;
            stored_reg      <= '0;
            closed_reg      <= 1'b0;
            full_reg        <= '0;
            done_reg        <= '0;
            result_strobe   <= 1'b0;
            result          <= '0;
        end
        else
        begin
            result_strobe <= strobe_next;
            if (strobe_next)
                result <= result_next;
            if (cmd.capture)
                done_reg <= '0;
            if (cmd.exec)
            begin
                case (req_reg.opcode)
                    OP_ADMIT:
                    begin
                        if (grant)
                        begin
                            ops_reg[ln]   <= cur_ops + 13'd1;
                            bytes_reg[ln] <= sum_bytes[31:0];
                            issue_seq_reg <= issue_seq_reg + 16'd1;
                        end
                    end
                    OP_COMPLETE:
                    begin
                        if (in_window && !dup)
                        begin
                            full_reg[widx] <= 1'b1;
                            stored_reg     <= stored_reg + 1'b1;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (!rel_under)
                        begin
                            ops_reg[ln]   <= cur_ops - 13'd1;
                            bytes_reg[ln] <= cur_bytes - req_reg.byte_cost;
                        end
                    end
                    OP_CLOSE:
                    begin
                        closed_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.drain_wb)
            begin
                if (!d_under)
                begin
                    ops_reg[d_lane]   <= ops_reg[d_lane] - 13'd1;
                    bytes_reg[d_lane] <= bytes_reg[d_lane] - d_bytes;
                end
                full_reg[head_reg] <= 1'b0;
                stored_reg         <= stored_reg - 1'b1;
                deliver_seq_reg    <= deliver_seq_reg + 16'd1;
                head_reg           <= (head_reg == IW'(REORDER_SLOTS - 1))
                                      ? '0 : head_reg + 1'b1;
                done_reg           <= done_reg + 6'd1;
            end
        end
    end

    // Stored count tracks the full flags
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg == ($countones(full_reg)))
        else $error("stored count disagrees with slot flags");

    // Stored count never exceeds the slot count
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= (IW+1)'(REORDER_SLOTS))
        else $error("stored count above slot count");

    // A delivery beat only comes from a full head slot
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_rd |-> full_reg[head_reg])
        else $error("read of empty head slot");

endmodule
`default_nettype wire
